// ===== design/dtq_pkg.sv =====
// Shared types and constants for the direction-exclusive token queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int ID_W    = 16;
  localparam int CLS_W   = 3;
  localparam int HOLD_W  = 5;
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  localparam logic [HOLD_W-1:0] HOLDERS_RESET = HOLD_W'(4);

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  // Register index of max_holders, taken from the word address.
  localparam logic [PADDR_W-3:0] REG_MAX_HOLDERS = '0;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [CLS_W-1:0]   cls;
  } item_t;

  // Signals rippled from one cell to the next, head of the queue first.
  typedef struct packed {
    logic hit;       // the id has matched at this cell or an earlier one
    logic blocked;   // an earlier occupied entry has a different class
    logic grant_ok;  // first match lies below the holder limit
  } chain_t;

endpackage

`default_nettype wire

// ===== design/dtq_if.sv =====
// Handshake interfaces for the input words and result words of the queue.
// Depends on dtq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dtq_item_if;
  import dtq_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [ID_W-1:0]  requester_id;
  logic [CLS_W-1:0] direction_class;

  modport source (output valid, kind, requester_id, direction_class, input ready);
  modport sink   (input valid, kind, requester_id, direction_class, output ready);
endinterface

interface dtq_result_if;
  logic valid;
  logic ready;
  logic granted;
  logic found;
  logic overflow;

  modport source (output valid, granted, found, overflow, input ready);
  modport sink   (input valid, granted, found, overflow, output ready);
endinterface

`default_nettype wire

// ===== design/dtq_cell.sv =====
// One queue position: holds an id and its class, compares against the word
// under evaluation and ripples match and blocking state on. Uses dtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell (
  input  wire                      clk,
  input  wire dtq_pkg::item_t      item,
  input  wire                      occupied,
  input  wire                      holder_ok,
  input  wire                      append_here,
  input  wire                      shift_req,
  input  wire [dtq_pkg::ID_W-1:0]  next_id,
  input  wire [dtq_pkg::CLS_W-1:0] next_cls,
  input  wire dtq_pkg::chain_t     chain_in,
  output dtq_pkg::chain_t          chain_out,
  output logic [dtq_pkg::ID_W-1:0] id,
  output logic [dtq_pkg::CLS_W-1:0] cls
);
  import dtq_pkg::*;

  logic match;
  logic differ;

  assign match  = occupied && (id == item.id);
  assign differ = occupied && (cls != item.cls);

  // Once the id has been found, later entries no longer count as blockers.
  assign chain_out.hit      = chain_in.hit | match;
  assign chain_out.blocked  = chain_in.blocked | (!chain_in.hit && !match && differ);
  assign chain_out.grant_ok = chain_in.grant_ok | (!chain_in.hit && match && holder_ok);

  always_ff @(posedge clk) begin
    if (append_here) begin
      id  <= item.id;
      cls <= item.cls;
    end else if (shift_req && (chain_in.hit || match)) begin
      id  <= next_id;
      cls <= next_cls;
    end
  end

endmodule

`default_nettype wire

// ===== design/direction_exclusive_token_queue.sv =====
// Direction-exclusive token queue, top level; uses dtq_pkg, dtq_if, dtq_cell.
// A word is registered at acceptance, and its result is registered when the
// word is evaluated, which waits while an untaken result holds the output.
// Only one word is held at a time, so a new word is taken only once the last one
// has been evaluated; the evaluation ripples through the whole row of cells.
// Reset: queue empty, max_holders 4; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module direction_exclusive_token_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [dtq_pkg::PADDR_W-1:0]   paddr,
  input  wire [dtq_pkg::APB_DW-1:0]    pwdata,
  output logic [dtq_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  dtq_item_if.sink                     item,
  dtq_result_if.source                 result
);
  import dtq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register. Only the first word address holds a register;
  // writes elsewhere are ignored and read back as zero.
  logic [HOLD_W-1:0] max_holders;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_MAX_HOLDERS);
  assign prdata  = reg_sel ? APB_DW'(max_holders) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_holders <= HOLDERS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_holders <= pwdata[HOLD_W-1:0];
    end
  end

  // Holding register for the word under evaluation. A new word is taken as
  // soon as the previous one has been evaluated, even while its result is
  // still waiting in the output register.
  logic       busy;
  item_t      cur;
  logic       fire_in;
  logic       compute;
  logic [CNT_W-1:0] count;

  assign item.ready = !busy;
  assign fire_in    = item.valid && !busy;
  assign compute    = busy && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fire_in) begin
      busy <= 1'b1;
    end else if (compute) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      cur.kind <= kind_t'(item.kind);
      cur.id   <= item.requester_id;
      cur.cls  <= item.direction_class;
    end
  end

  // Row of cells. Position zero is the head of the queue; the match and
  // blocking signals ripple from the head towards the tail.
  chain_t            chain [QUEUE_DEPTH+1];
  logic [ID_W-1:0]   cell_id  [QUEUE_DEPTH];
  logic [CLS_W-1:0]  cell_cls [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] holder_ok;
  logic [QUEUE_DEPTH-1:0] append_here;

  logic is_req;
  logic is_rel;
  logic hit;
  logic full;
  logic do_append;
  logic shift_req;

  assign chain[0]  = '{hit: 1'b0, blocked: 1'b0, grant_ok: 1'b0};
  assign hit       = chain[QUEUE_DEPTH].hit;
  assign is_req    = (cur.kind == KIND_REQUEST);
  assign is_rel    = (cur.kind == KIND_RELEASE);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign do_append = compute && is_req && !hit && !full;
  assign shift_req = compute && is_rel && hit;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  nid;
    logic [CLS_W-1:0] ncls;

    assign occupied[i]    = (CNT_W'(i) < count);
    assign holder_ok[i]   = (32'(i) < 32'(max_holders));
    assign append_here[i] = do_append && (count == CNT_W'(i));

    // The tail cell has no neighbour behind it; its contents fall outside
    // the queue after a removal, so it simply keeps what it holds.
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nid  = cell_id[i];
      assign ncls = cell_cls[i];
    end else begin : g_body
      assign nid  = cell_id[i+1];
      assign ncls = cell_cls[i+1];
    end

    dtq_cell u_cell (
      .clk         (clk),
      .item        (cur),
      .occupied    (occupied[i]),
      .holder_ok   (holder_ok[i]),
      .append_here (append_here[i]),
      .shift_req   (shift_req),
      .next_id     (nid),
      .next_cls    (ncls),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .id          (cell_id[i]),
      .cls         (cell_cls[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_append) begin
      count <= count + CNT_W'(1);
    end else if (shift_req) begin
      count <= count - CNT_W'(1);
    end
  end

  // Result evaluation. A freshly appended id sits at the old tail position,
  // and every occupied entry lies ahead of it, so the blocking flag from the
  // end of the row is the one that applies in both cases.
  logic pos_ok;
  logic res_granted;
  logic res_found;
  logic res_overflow;

  assign pos_ok       = hit ? chain[QUEUE_DEPTH].grant_ok
                            : (!full && (32'(count) < 32'(max_holders)));
  assign res_granted  = is_req && pos_ok && !chain[QUEUE_DEPTH].blocked;
  assign res_found    = is_rel && hit;
  assign res_overflow = is_req && !hit && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (compute) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      result.granted  <= res_granted;
      result.found    <= res_found;
      result.overflow <= res_overflow;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    compute |=> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                 count == $past(count) - CNT_W'(1)))
    else $error("queue fill count moved by more than one");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.found && (result.granted || result.overflow)))
    else $error("release result carries request flags");

  a_overflow_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.granted && result.overflow))
    else $error("grant given on an overflowed request");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for direction_exclusive_token_queue: directed words, then random traffic.
// Depends on dtq_pkg, dtq_item_if, dtq_result_if and the block's RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import dtq_pkg::*;

  localparam int          DEPTH       = 16;
  localparam int          POOL_N      = 48;
  localparam int          HOLD_OFF    = 150;     // cycles the receiver refuses results once
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result word as the block reports it.
  typedef struct packed {
    logic granted;
    logic found;
    logic overflow;
  } verdict_t;

  localparam verdict_t QUIET    = '0;
  localparam verdict_t GRANTED  = '{granted: 1'b1, found: 1'b0, overflow: 1'b0};
  localparam verdict_t FOUND    = '{granted: 1'b0, found: 1'b1, overflow: 1'b0};
  localparam verdict_t OVERFLOW = '{granted: 1'b0, found: 1'b0, overflow: 1'b1};

  // A row of the directed table. Where typed is set, the verdict is written out by hand.
  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    logic             typed;
    verdict_t         verdict;
  } probe_t;

  // A phase of random traffic: holder limit (negative picks one at random), length,
  // number of ids in play and the share of requests in per cent.
  typedef struct packed {
    int holders;
    int words;
    int pool_n;
    int req_pct;
  } phase_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  dtq_item_if   item_bus ();
  dtq_result_if result_bus ();

  direction_exclusive_token_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .item   (item_bus.sink),
    .result (result_bus.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // The directed table starts from an empty queue with the reset holder limit of four.
  // It builds a queue with mixed classes, fills it to the brim, overflows it and
  // then frees one place again.
  probe_t probes [26] = '{
    '{KIND_RELEASE, 16'h1234, 3'd5, 1'b1, QUIET},     // release on an empty queue
    '{KIND_REQUEST, 16'h0000, 3'd0, 1'b1, GRANTED},   // first word takes the head
    '{KIND_REQUEST, 16'hFFFF, 3'd7, 1'b0, QUIET},     // blocked by a different class ahead
    '{KIND_REQUEST, 16'h0000, 3'd7, 1'b0, QUIET},     // already at the head, asks with a new class
    '{KIND_REQUEST, 16'h0001, 3'd0, 1'b0, QUIET},
    '{KIND_RELEASE, 16'hFFFF, 3'd2, 1'b1, FOUND},     // removal from the middle
    '{KIND_REQUEST, 16'h0001, 3'd0, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h0002, 3'd0, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h0003, 3'd0, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h0004, 3'd0, 1'b0, QUIET},     // beyond the holder limit
    '{KIND_REQUEST, 16'h5A5A, 3'd1, 1'b0, QUIET},
    '{KIND_REQUEST, 16'hA5A5, 3'd2, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h0F0F, 3'd3, 1'b0, QUIET},
    '{KIND_REQUEST, 16'hF0F0, 3'd4, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h00FF, 3'd5, 1'b0, QUIET},
    '{KIND_REQUEST, 16'hFF00, 3'd6, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h3333, 3'd7, 1'b0, QUIET},
    '{KIND_REQUEST, 16'hCCCC, 3'd0, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h5555, 3'd1, 1'b0, QUIET},
    '{KIND_REQUEST, 16'hAAAA, 3'd2, 1'b0, QUIET},
    '{KIND_REQUEST, 16'h7FFF, 3'd3, 1'b0, QUIET},     // sixteenth entry: queue now full
    '{KIND_REQUEST, 16'h8000, 3'd3, 1'b1, OVERFLOW},  // new id on a full queue is dropped
    '{KIND_REQUEST, 16'h0002, 3'd0, 1'b0, QUIET},     // known id on a full queue
    '{KIND_RELEASE, 16'h0000, 3'd0, 1'b1, FOUND},     // head leaves, all shift forward
    '{KIND_REQUEST, 16'h8000, 3'd3, 1'b0, QUIET},     // now fits at the tail
    '{KIND_RELEASE, 16'h4321, 3'd6, 1'b1, QUIET}      // release of an id never queued
  };

  // Random phases run through the extremes of the holder limit: the reset value, one,
  // the queue depth, zero (nothing is ever granted), the largest the register holds,
  // then two, one past the depth, and three picked at random.
  phase_t phases [10] = '{
    '{4,  150, 20, 60},
    '{1,  150, 24, 75},
    '{16, 200, 20, 65},
    '{0,  120, 20, 50},
    '{31, 200, 40, 85},
    '{2,  150, 12, 50},
    '{17, 150, 32, 60},
    '{-1, 130, 24, 60},
    '{-1, 130, 24, 40},
    '{-1, 130, 24, 70}
  };

  // Our own picture of the arbiter: queued ids, their stored classes and the holder limit.
  logic [ID_W-1:0]   held_ids [DEPTH];
  logic [CLS_W-1:0]  held_cls [DEPTH];
  int                held_n;
  logic [HOLD_W-1:0] holder_limit;

  verdict_t          owed_verdicts [$];
  logic [ID_W-1:0]   id_pool [POOL_N];
  int unsigned       words_sent;
  int unsigned       results_seen;
  int unsigned       cycles;
  int                errors;
  verdict_t          oldest;
  bit                held_once;

  // Works out the verdict for one accepted word and moves the queue picture on.
  function automatic verdict_t arbitrate(kind_t k, logic [ID_W-1:0] id,
                                         logic [CLS_W-1:0] cls);
    verdict_t v;
    int       pos;
    bit       clash;
    v     = QUIET;
    pos   = held_n;
    clash = 1'b0;
    for (int i = 0; i < held_n; i++) begin
      if (pos == held_n && held_ids[i] == id) pos = i;
    end
    if (k == KIND_REQUEST) begin
      // An id not yet queued joins the tail, or is dropped if there is no room.
      if (pos == held_n) begin
        if (held_n >= DEPTH) begin
          v.overflow = 1'b1;
        end else begin
          held_ids[held_n] = id;
          held_cls[held_n] = cls;
          held_n++;
        end
      end
      // The grant compares against the class given now, not the one stored.
      if (!v.overflow && pos < int'(holder_limit)) begin
        for (int i = 0; i < pos; i++) begin
          if (held_cls[i] != cls) clash = 1'b1;
        end
        v.granted = !clash;
      end
    end else if (pos < held_n) begin
      for (int i = pos; i < held_n - 1; i++) begin
        held_ids[i] = held_ids[i + 1];
        held_cls[i] = held_cls[i + 1];
      end
      held_n--;
      v.found = 1'b1;
    end
    return v;
  endfunction

  // Offers one word, with a random gap in front of it except during the stretch of
  // back-to-back traffic, and files its expected verdict once the block takes it.
  task automatic offer_word(kind_t k, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls,
                            logic typed, verdict_t typed_verdict);
    int unsigned gap;
    verdict_t    v;
    gap = 0;
    if ((words_sent < 400 || words_sent >= 600) && $urandom_range(0, 99) < 30)
      gap = $urandom_range(1, 4);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid           <= 1'b1;
    item_bus.kind            <= k;
    item_bus.requester_id    <= id;
    item_bus.direction_class <= cls;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    // The word was taken at this edge; the predictor state moves with it.
    v = arbitrate(k, id, cls);
    owed_verdicts.push_back(typed ? typed_verdict : v);
    words_sent++;
  endtask

  // Lowers valid and waits until every word sent so far has had its result.
  // Every word yields exactly one result, so the block is then idle.
  task automatic drain;
    item_bus.valid <= 1'b0;
    while (owed_verdicts.size() != 0) @(posedge clk);
  endtask

  // APB write of max_holders: the setup phase, then the access phase.
  task automatic set_holder_limit(logic [HOLD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_HOLDERS, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    holder_limit  = value;
  endtask

  task automatic check_bit(string field, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      errors++;
    end
  endtask

  // Results are compared in order against the oldest outstanding verdict. A result
  // turning up with nothing outstanding is an error in itself.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (owed_verdicts.size() == 0) begin
        $error("result word with no verdict outstanding");
        errors++;
      end else begin
        oldest = owed_verdicts.pop_front();
        check_bit("granted", oldest.granted, result_bus.granted);
        check_bit("found", oldest.found, result_bus.found);
        check_bit("overflow", oldest.overflow, result_bus.overflow);
      end
      results_seen++;
    end
  end

  // The receiving side. Once, after a few hundred results, it refuses everything for a
  // long stretch while the sender keeps offering, so the block fills and stalls its
  // input. A later stretch, alongside the sender's back-to-back stretch, takes every
  // result at once; otherwise it stalls at random.
  initial begin
    result_bus.ready = 1'b0;
    held_once        = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      if (results_seen >= 400 && results_seen < 600)
        result_bus.ready <= 1'b1;
      else
        result_bus.ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("direction_exclusive_token_queue regression: fail");
    $finish;
  end

  initial begin
    kind_t            k;
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    logic [HOLD_W-1:0] limit;

    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    item_bus.valid           = 1'b0;
    item_bus.kind            = KIND_REQUEST;
    item_bus.requester_id    = '0;
    item_bus.direction_class = '0;
    held_n                   = 0;
    holder_limit             = HOLDERS_RESET;
    words_sent               = 0;
    results_seen             = 0;
    errors                   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The ids that the directed table leaves queued head the pool, so that the random
    // traffic releases them again; the rest of the pool is random.
    for (int i = 0; i < POOL_N; i++)
      id_pool[i] = (i < 16) ? probes[i + 6].id : ID_W'($urandom);

    foreach (probes[i])
      offer_word(probes[i].kind, probes[i].id, probes[i].cls, probes[i].typed,
                 probes[i].verdict);
    drain();

    // Random traffic. Most words use ids from a small pool, so that requests meet
    // queued ids, releases find them and the queue runs full; a few carry a fully
    // random id. Classes lean towards two values, so that grants are common.
    foreach (phases[p]) begin
      limit = (phases[p].holders < 0) ? HOLD_W'($urandom_range(0, 31))
                                      : HOLD_W'(phases[p].holders);
      set_holder_limit(limit);
      for (int n = 0; n < phases[p].words; n++) begin
        k   = ($urandom_range(0, 99) < phases[p].req_pct) ? KIND_REQUEST : KIND_RELEASE;
        id  = ($urandom_range(0, 99) < 5) ? ID_W'($urandom)
                                          : id_pool[$urandom_range(0, phases[p].pool_n - 1)];
        cls = ($urandom_range(0, 99) < 70) ? CLS_W'($urandom_range(0, 1))
                                           : CLS_W'($urandom_range(0, 7));
        offer_word(k, id, cls, 1'b0, QUIET);
      end
      drain();
    end

    // The closing wait catches any stray result word.
    repeat (6) @(posedge clk);
    if (errors == 0 && owed_verdicts.size() == 0) begin
      $display("direction_exclusive_token_queue regression: pass");
    end else begin
      $display("direction_exclusive_token_queue regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dtq_pkg.sv
design/dtq_if.sv
design/dtq_cell.sv
design/direction_exclusive_token_queue.sv
tb/sv/tb_top.sv
